/* hw/rtl/backlight_fade_controller_core_defines.svh */
// assertion macros shared by the backlight fade controller rtl
// no dependencies; included by files that carry concurrent checks
`ifndef BACKLIGHT_FADE_CONTROLLER_CORE_DEFINES_SVH
`define BACKLIGHT_FADE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BFC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bfc check failed: same-cycle implication");

// next-cycle implication
`define BFC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bfc check failed: next-cycle implication");

`endif

/* hw/rtl/bfc_pkg.sv */
// constants, register codes and reset values of the backlight fade controller
// no dependencies; used by backlight_fade_controller_core
package bfc_pkg;

    localparam int LVL_W  = 7;
    localparam int IDLE_W = 16;
    localparam int GAP_W  = 2;
    localparam int PCNT_W = 7;
    localparam int DUTY_W = 8;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 16;
    localparam int PROD_W = 15;   // 100 * 255 fits in 15 bits

    // timing parameters, in ticks
    localparam logic [GAP_W-1:0]  RAMP_GAP_TICKS   = 2'd2;
    localparam logic [PCNT_W-1:0] PULSE_HALF_TICKS = 7'd60;

    // saturation limits of the timers
    localparam logic [GAP_W-1:0]  GAP_MAX  = 2'd3;
    localparam logic [PCNT_W-1:0] PCNT_MAX = 7'd127;
    localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

    localparam logic [LVL_W-1:0] PCT_FULL = 7'd100;

    // divide by 100: floor(x * 5243 / 2^19) is exact for x <= 25500
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int               RECIP_SHIFT = 19;
    localparam int               QPROD_W     = PROD_W + RECIP_W;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_LEVEL_HIGH      = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LEVEL_LOW       = 3'd1;
    localparam logic [CIDX_W-1:0] REG_STEP_UP         = 3'd2;
    localparam logic [CIDX_W-1:0] REG_STEP_DOWN       = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PULSE_STEP_UP   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_PULSE_STEP_DOWN = 3'd5;
    localparam logic [CIDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd6;
    localparam logic [CIDX_W-1:0] REG_PWM_FULL        = 3'd7;

    // reset values
    localparam logic [LVL_W-1:0]  RST_LEVEL_HIGH      = 7'd100;
    localparam logic [LVL_W-1:0]  RST_LEVEL_LOW       = 7'd10;
    localparam logic [LVL_W-1:0]  RST_STEP_UP         = 7'd5;
    localparam logic [LVL_W-1:0]  RST_STEP_DOWN       = 7'd1;
    localparam logic [LVL_W-1:0]  RST_PULSE_STEP_UP   = 7'd5;
    localparam logic [LVL_W-1:0]  RST_PULSE_STEP_DOWN = 7'd5;
    localparam logic [IDLE_W-1:0] RST_IDLE_TIMEOUT    = 16'd3000;
    localparam logic [DUTY_W-1:0] RST_PWM_FULL        = 8'd255;
    localparam logic [LVL_W-1:0]  RST_LEVEL           = 7'd100;

endpackage

/* hw/rtl/backlight_fade_controller_core.sv */
// backlight fade controller: brightness ramp, idle dimming, pulsing, pwm duty
// depends on bfc_pkg and backlight_fade_controller_core_defines.svh
//
//   channel | ports                                 | direction
//   --------+---------------------------------------+-----------
//   s_      | s_valid s_ready s_activity s_pulse_mode | in, one tick per item
//   m_      | m_valid m_ready m_pwm_duty m_brightness | out, one item per tick
//   cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | in, register writes
//
// throughput is one item per cycle unless m_ready stalls; three register stages
// (input, state update with duty product, divide by 100) pass each item on to
// m_valid; each stage holds while the stage behind it is full and stalled, so
// a stall on m_ready backs up to s_ready only once all three stages are full
// aresetn is synchronous and active low; it restores register reset values,
// full brightness and cleared timers; cfg_ready is always high
`include "backlight_fade_controller_core_defines.svh"

module backlight_fade_controller_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tick items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_activity,
    input  logic                         s_pulse_mode,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bfc_pkg::DUTY_W-1:0]   m_pwm_duty,
    output logic [bfc_pkg::LVL_W-1:0]    m_brightness,
    // register writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bfc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [bfc_pkg::CDAT_W-1:0]   cfg_data
);

    // configuration registers
    logic [bfc_pkg::LVL_W-1:0]  level_high_reg;
    logic [bfc_pkg::LVL_W-1:0]  level_low_reg;
    logic [bfc_pkg::LVL_W-1:0]  step_up_reg;
    logic [bfc_pkg::LVL_W-1:0]  step_down_reg;
    logic [bfc_pkg::LVL_W-1:0]  pulse_step_up_reg;
    logic [bfc_pkg::LVL_W-1:0]  pulse_step_down_reg;
    logic [bfc_pkg::IDLE_W-1:0] idle_timeout_reg;
    logic [bfc_pkg::DUTY_W-1:0] pwm_full_reg;

    // block state
    logic [bfc_pkg::LVL_W-1:0]  level_reg,       level_next;
    logic [bfc_pkg::IDLE_W-1:0] idle_count_reg,  idle_count_next;
    logic [bfc_pkg::GAP_W-1:0]  gap_count_reg,   gap_count_next;
    logic [bfc_pkg::PCNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic                       pulse_phase_reg, pulse_phase_next;

    // pipeline registers
    logic                        in_vld_reg;
    logic                        in_act_reg;
    logic                        in_pulse_reg;
    logic                        st1_vld_reg;
    logic [bfc_pkg::PROD_W-1:0]  st1_prod_reg,  st1_prod_next;
    logic [bfc_pkg::LVL_W-1:0]   st1_level_reg;
    logic                        out_vld_reg;
    logic [bfc_pkg::DUTY_W-1:0]  out_duty_reg,  out_duty_next;
    logic [bfc_pkg::LVL_W-1:0]   out_level_reg;

    // stage handshakes
    logic out_rdy;
    logic st1_rdy;
    logic in_rdy;
    logic adv0;     // stage 0 item moves on and updates the state

    // stage 0 datapath
    logic [bfc_pkg::IDLE_W-1:0] idle_eff;
    logic                       rising;
    logic [bfc_pkg::LVL_W-1:0]  step;
    logic                       gap_ok;
    logic [bfc_pkg::LVL_W:0]    up_sum;
    logic [bfc_pkg::LVL_W:0]    low_plus;
    logic                       stepped;
    logic                       flipped;
    logic [bfc_pkg::LVL_W-1:0]  pct;

    // stage 1 datapath
    logic [bfc_pkg::QPROD_W-1:0] qprod;

    // ready chain: a stage takes an item when empty or when it empties now
    assign out_rdy  = !out_vld_reg || m_ready;
    assign st1_rdy  = !st1_vld_reg || out_rdy;
    assign in_rdy   = !in_vld_reg  || st1_rdy;
    assign adv0     = in_vld_reg && st1_rdy;

    assign s_ready   = in_rdy;
    assign cfg_ready = 1'b1;

    assign m_valid      = out_vld_reg;
    assign m_pwm_duty   = out_duty_reg;
    assign m_brightness = out_level_reg;

    // configuration writes, value truncated to the register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_high_reg      <= bfc_pkg::RST_LEVEL_HIGH;
            level_low_reg       <= bfc_pkg::RST_LEVEL_LOW;
            step_up_reg         <= bfc_pkg::RST_STEP_UP;
            step_down_reg       <= bfc_pkg::RST_STEP_DOWN;
            pulse_step_up_reg   <= bfc_pkg::RST_PULSE_STEP_UP;
            pulse_step_down_reg <= bfc_pkg::RST_PULSE_STEP_DOWN;
            idle_timeout_reg    <= bfc_pkg::RST_IDLE_TIMEOUT;
            pwm_full_reg        <= bfc_pkg::RST_PWM_FULL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bfc_pkg::REG_LEVEL_HIGH: begin
                    level_high_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_LEVEL_LOW: begin
                    level_low_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_STEP_UP: begin
                    step_up_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_STEP_DOWN: begin
                    step_down_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_PULSE_STEP_UP: begin
                    pulse_step_up_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_PULSE_STEP_DOWN: begin
                    pulse_step_down_reg <= cfg_data[bfc_pkg::LVL_W-1:0];
                end
                bfc_pkg::REG_IDLE_TIMEOUT: begin
                    idle_timeout_reg <= cfg_data[bfc_pkg::IDLE_W-1:0];
                end
                bfc_pkg::REG_PWM_FULL: begin
                    pwm_full_reg <= cfg_data[bfc_pkg::DUTY_W-1:0];
                end
            endcase
        end
    end

    // stage 0: one tick of the brightness state machine
    always_comb begin
        // activity restarts the idle timer only in normal mode
        idle_eff = (!in_pulse_reg && in_act_reg) ? '0 : idle_count_reg;

        if (in_pulse_reg) begin
            rising = !pulse_phase_reg;
            step   = pulse_phase_reg ? pulse_step_down_reg : pulse_step_up_reg;
        end else begin
            rising = (idle_eff < idle_timeout_reg);
            step   = rising ? step_up_reg : step_down_reg;
        end

        gap_ok   = (gap_count_reg >= bfc_pkg::RAMP_GAP_TICKS);
        up_sum   = {1'b0, level_reg} + {1'b0, step};
        low_plus = {1'b0, level_low_reg} + {1'b0, step};

        stepped    = 1'b0;
        level_next = level_reg;
        if (gap_ok) begin
            if (rising) begin
                // clamp at the high limit; a level already beyond it holds
                if (level_reg < level_high_reg) begin
                    stepped    = 1'b1;
                    level_next = (up_sum < {1'b0, level_high_reg})
                               ? up_sum[bfc_pkg::LVL_W-1:0] : level_high_reg;
                end
            end else begin
                if (level_reg > level_low_reg) begin
                    stepped    = 1'b1;
                    level_next = ({1'b0, level_reg} > low_plus)
                               ? (level_reg - step) : level_low_reg;
                end
            end
        end

        // pulse half period; the phase is held in normal mode
        flipped          = in_pulse_reg && (pulse_count_reg >= bfc_pkg::PULSE_HALF_TICKS);
        pulse_phase_next = pulse_phase_reg ^ flipped;

        // timers advance and saturate; a restarted timer reads one
        if (stepped) begin
            gap_count_next = {{(bfc_pkg::GAP_W-1){1'b0}}, 1'b1};
        end else if (gap_count_reg == bfc_pkg::GAP_MAX) begin
            gap_count_next = gap_count_reg;
        end else begin
            gap_count_next = gap_count_reg + 1'b1;
        end

        if (flipped) begin
            pulse_count_next = {{(bfc_pkg::PCNT_W-1){1'b0}}, 1'b1};
        end else if (pulse_count_reg == bfc_pkg::PCNT_MAX) begin
            pulse_count_next = pulse_count_reg;
        end else begin
            pulse_count_next = pulse_count_reg + 1'b1;
        end

        idle_count_next = (idle_eff == bfc_pkg::IDLE_MAX) ? idle_eff : (idle_eff + 1'b1);

        // duty product on the updated level, limited to 100 percent
        pct           = (level_next > bfc_pkg::PCT_FULL) ? bfc_pkg::PCT_FULL : level_next;
        st1_prod_next = bfc_pkg::PROD_W'(pct) * bfc_pkg::PROD_W'(pwm_full_reg);
    end

    // stage 1: divide the product by 100 through a reciprocal multiply
    always_comb begin
        qprod         = bfc_pkg::QPROD_W'(st1_prod_reg) * bfc_pkg::QPROD_W'(bfc_pkg::RECIP_100);
        out_duty_next = qprod[bfc_pkg::RECIP_SHIFT +: bfc_pkg::DUTY_W];
    end

    // state registers move only with a stage 0 item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= bfc_pkg::RST_LEVEL;
            idle_count_reg  <= '0;
            gap_count_reg   <= '0;
            pulse_count_reg <= '0;
            pulse_phase_reg <= 1'b0;
        end else if (adv0) begin
            level_reg       <= level_next;
            idle_count_reg  <= idle_count_next;
            gap_count_reg   <= gap_count_next;
            pulse_count_reg <= pulse_count_next;
            pulse_phase_reg <= pulse_phase_next;
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            st1_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_rdy) begin
                in_vld_reg <= s_valid;
            end
            if (st1_rdy) begin
                st1_vld_reg <= in_vld_reg;
            end
            if (out_rdy) begin
                out_vld_reg <= st1_vld_reg;
            end
        end
    end

    // pipeline payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_rdy && s_valid) begin
            in_act_reg   <= s_activity;
            in_pulse_reg <= s_pulse_mode;
        end
        if (adv0) begin
            st1_prod_reg  <= st1_prod_next;
            st1_level_reg <= level_next;
        end
        if (out_rdy && st1_vld_reg) begin
            out_duty_reg  <= out_duty_next;
            out_level_reg <= st1_level_reg;
        end
    end

    // a stalled input side means the input stage holds an item
    `BFC_ASSERT_IMP(a_stall_has_item, aclk, aresetn, !s_ready, in_vld_reg)
    // the level only changes when a tick is processed
    `BFC_ASSERT_NXT(a_level_hold, aclk, aresetn, !adv0, $stable(level_reg))
    // a ramp step restarts the gap timer at one
    `BFC_ASSERT_NXT(a_gap_restart, aclk, aresetn, adv0 && stepped, gap_count_reg == 2'd1)
    // the duty product never exceeds 100 percent of full scale
    `BFC_ASSERT_IMP(a_prod_range, aclk, aresetn, st1_vld_reg, st1_prod_reg <= 15'd25500)

endmodule

/* dv/tb_top.sv */
// self-checking testbench for backlight_fade_controller_core: directed corner ticks,
// then long random mode runs; every result item is checked against a local predictor
// depends on bfc_pkg and the backlight_fade_controller_core rtl
module tb_top;

    // run ends in failure past this many cycles
    localparam int CYCLE_LIMIT = 400000;
    // cycles to let the pipeline settle after the last result
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [bfc_pkg::DUTY_W-1:0] duty;
        logic [bfc_pkg::LVL_W-1:0]  brightness;
    } tick_result_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_activity;
    logic                         s_pulse_mode;
    logic                         m_valid;
    logic                         m_ready;
    logic [bfc_pkg::DUTY_W-1:0]   m_pwm_duty;
    logic [bfc_pkg::LVL_W-1:0]    m_brightness;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [bfc_pkg::CIDX_W-1:0]   cfg_index;
    logic [bfc_pkg::CDAT_W-1:0]   cfg_data;

    // predictor copy of the registers
    logic [bfc_pkg::LVL_W-1:0]    level_high_r;
    logic [bfc_pkg::LVL_W-1:0]    level_low_r;
    logic [bfc_pkg::LVL_W-1:0]    step_up_r;
    logic [bfc_pkg::LVL_W-1:0]    step_down_r;
    logic [bfc_pkg::LVL_W-1:0]    pulse_step_up_r;
    logic [bfc_pkg::LVL_W-1:0]    pulse_step_down_r;
    logic [bfc_pkg::IDLE_W-1:0]   idle_timeout_r;
    logic [bfc_pkg::DUTY_W-1:0]   pwm_full_r;

    // predictor copy of the state
    logic [bfc_pkg::LVL_W-1:0]    level_q;
    logic [bfc_pkg::IDLE_W-1:0]   idle_q;
    logic [bfc_pkg::GAP_W-1:0]    gap_q;
    logic [bfc_pkg::PCNT_W-1:0]   pcnt_q;
    logic                         falling_q;

    tick_result_t        pending_results[$];
    tick_result_t        oldest_result;
    int                  err_count;
    int                  cycle_count;
    bit                  idle_en;

    backlight_fade_controller_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_activity   (s_activity),
        .s_pulse_mode (s_pulse_mode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pwm_duty   (m_pwm_duty),
        .m_brightness (m_brightness),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // registers and state as they come out of reset
    task automatic reset_model();
        level_high_r      = bfc_pkg::RST_LEVEL_HIGH;
        level_low_r       = bfc_pkg::RST_LEVEL_LOW;
        step_up_r         = bfc_pkg::RST_STEP_UP;
        step_down_r       = bfc_pkg::RST_STEP_DOWN;
        pulse_step_up_r   = bfc_pkg::RST_PULSE_STEP_UP;
        pulse_step_down_r = bfc_pkg::RST_PULSE_STEP_DOWN;
        idle_timeout_r    = bfc_pkg::RST_IDLE_TIMEOUT;
        pwm_full_r        = bfc_pkg::RST_PWM_FULL;
        level_q           = bfc_pkg::RST_LEVEL;
        idle_q            = '0;
        gap_q             = '0;
        pcnt_q            = '0;
        falling_q         = 1'b0;
    endtask

    // register write as seen by the predictor; 7-bit registers keep the low bits
    function automatic void apply_reg(input logic [bfc_pkg::CIDX_W-1:0] idx,
                                      input logic [bfc_pkg::CDAT_W-1:0] data);
        case (idx)
            bfc_pkg::REG_LEVEL_HIGH:      level_high_r      = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_LEVEL_LOW:       level_low_r       = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_STEP_UP:         step_up_r         = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_STEP_DOWN:       step_down_r       = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_PULSE_STEP_UP:   pulse_step_up_r   = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_PULSE_STEP_DOWN: pulse_step_down_r = data[bfc_pkg::LVL_W-1:0];
            bfc_pkg::REG_IDLE_TIMEOUT:    idle_timeout_r    = data[bfc_pkg::IDLE_W-1:0];
            bfc_pkg::REG_PWM_FULL:        pwm_full_r        = data[bfc_pkg::DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    // one tick: ramp decision, clamp, timer update, duty
    function automatic tick_result_t fade_tick(input logic act, input logic pulse);
        tick_result_t res;
        int           lvl;
        int           stp;
        int           pct;
        bit           rising;
        bit           stepped;
        bit           flipped;
        lvl     = int'(level_q);
        stepped = 1'b0;
        flipped = 1'b0;
        if (!pulse) begin
            // key activity restarts the idle timer before the direction is chosen
            if (act) begin
                idle_q = '0;
            end
            rising = (idle_q < idle_timeout_r);
            stp    = rising ? int'(step_up_r) : int'(step_down_r);
        end else begin
            // activity ignored; direction follows the pulse phase
            rising  = !falling_q;
            stp     = rising ? int'(pulse_step_up_r) : int'(pulse_step_down_r);
            flipped = (pcnt_q >= bfc_pkg::PULSE_HALF_TICKS);
        end
        if (gap_q >= bfc_pkg::RAMP_GAP_TICKS) begin
            // a level already at or past its target limit is held
            if (rising) begin
                if (lvl < int'(level_high_r)) begin
                    lvl     = (lvl + stp < int'(level_high_r)) ? lvl + stp : int'(level_high_r);
                    stepped = 1'b1;
                end
            end else if (lvl > int'(level_low_r)) begin
                lvl     = (lvl > int'(level_low_r) + stp) ? lvl - stp : int'(level_low_r);
                stepped = 1'b1;
            end
        end
        level_q = lvl[bfc_pkg::LVL_W-1:0];
        if (flipped) begin
            falling_q = !falling_q;
        end
        // saturating timers; a restarted timer reads one
        gap_q  = stepped ? bfc_pkg::GAP_W'(1)
               : ((gap_q >= bfc_pkg::GAP_MAX) ? bfc_pkg::GAP_MAX : gap_q + 1'b1);
        pcnt_q = flipped ? bfc_pkg::PCNT_W'(1)
               : ((pcnt_q >= bfc_pkg::PCNT_MAX) ? bfc_pkg::PCNT_MAX : pcnt_q + 1'b1);
        idle_q = (idle_q >= bfc_pkg::IDLE_MAX) ? bfc_pkg::IDLE_MAX : idle_q + 1'b1;
        // duty never goes past full scale even when the level is above 100
        pct = (int'(level_q) > int'(bfc_pkg::PCT_FULL)) ? int'(bfc_pkg::PCT_FULL)
                                                         : int'(level_q);
        res.duty       = bfc_pkg::DUTY_W'((pct * int'(pwm_full_r)) / int'(bfc_pkg::PCT_FULL));
        res.brightness = level_q;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one tick item; called at a falling edge, returns at a falling edge
    task automatic send_tick(input logic act, input logic pulse);
        while (idle_en && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_activity   <= act;
        s_pulse_mode <= pulse;
        do @(posedge aclk); while (!s_ready);
        // item accepted on this edge
        pending_results.push_back(fade_tick(act, pulse));
        @(negedge aclk);
    endtask

    // one register write; valid is dropped for a cycle afterwards
    task automatic write_reg(input logic [bfc_pkg::CIDX_W-1:0] idx,
                             input logic [bfc_pkg::CDAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // stop sending and wait for every expected item, then let the pipeline empty
    task automatic settle_ticks();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // random stimulus helpers
    // ---------------------------------------------------------------

    // brightness limit: extremes, past 100, or anywhere in range
    function automatic logic [bfc_pkg::CDAT_W-1:0] pick_limit();
        case ($urandom_range(5))
            0: return 0;
            1: return 100;
            2: return bfc_pkg::CDAT_W'($urandom_range(127, 101));
            default: return bfc_pkg::CDAT_W'($urandom_range(100));
        endcase
    endfunction

    // ramp step: mostly small so ramps last several steps
    function automatic logic [bfc_pkg::CDAT_W-1:0] pick_step();
        case ($urandom_range(5))
            0: return 0;
            1: return 100;
            default: return bfc_pkg::CDAT_W'($urandom_range(20, 1));
        endcase
    endfunction

    // new value for every register
    task automatic randomize_regs();
        logic [bfc_pkg::CDAT_W-1:0] idle_val;
        logic [bfc_pkg::CDAT_W-1:0] full_val;
        case ($urandom_range(5))
            0: idle_val = 0;
            1: idle_val = bfc_pkg::IDLE_MAX;
            2: idle_val = bfc_pkg::CDAT_W'($urandom_range(65535));
            default: idle_val = bfc_pkg::CDAT_W'($urandom_range(60, 1));
        endcase
        case ($urandom_range(3))
            0: full_val = 0;
            1: full_val = 255;
            default: full_val = bfc_pkg::CDAT_W'($urandom_range(255));
        endcase
        write_reg(bfc_pkg::REG_LEVEL_HIGH, pick_limit());
        write_reg(bfc_pkg::REG_LEVEL_LOW, pick_limit());
        write_reg(bfc_pkg::REG_STEP_UP, pick_step());
        write_reg(bfc_pkg::REG_STEP_DOWN, pick_step());
        write_reg(bfc_pkg::REG_PULSE_STEP_UP, pick_step());
        write_reg(bfc_pkg::REG_PULSE_STEP_DOWN, pick_step());
        write_reg(bfc_pkg::REG_IDLE_TIMEOUT, idle_val);
        write_reg(bfc_pkg::REG_PWM_FULL, full_val);
    endtask

    // runs of one mode long enough to reach dimming and pulse flips,
    // with short bursts of mixed ticks in between
    task automatic run_random_ticks(input int count);
        int   left;
        int   len;
        int   kind;
        int   act_pct;
        logic pulse;
        left = count;
        while (left > 0) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                pulse   = 1'b1;
                len     = $urandom_range(130, 20);
                act_pct = $urandom_range(99);
            end else if (kind < 90) begin
                pulse = 1'b0;
                len   = $urandom_range(80, 10);
                case ($urandom_range(3))
                    0: act_pct = 0;
                    1: act_pct = 3;
                    2: act_pct = 30;
                    default: act_pct = 90;
                endcase
            end else begin
                pulse   = 1'b0;
                len     = $urandom_range(8, 1);
                act_pct = -1;
            end
            if (len > left) begin
                len = left;
            end
            for (int i = 0; i < len; i++) begin
                if (act_pct < 0) begin
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    send_tick(int'($urandom_range(99)) < act_pct, pulse);
                end
            end
            left -= len;
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset registers: level starts at the high limit and is held
    task automatic test_reset_levels();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        settle_ticks();
    endtask

    // zero idle timeout ramps down even with activity; big step clamps at low
    task automatic test_zero_timeout();
        write_reg(bfc_pkg::REG_IDLE_TIMEOUT, 0);
        repeat (4) send_tick(1'b1, 1'b0);
        settle_ticks();
        write_reg(bfc_pkg::REG_STEP_DOWN, 100);
        repeat (2) send_tick(1'b1, 1'b0);
        settle_ticks();
    endtask

    // high limit past 100: level climbs above 100, duty stays at full scale
    task automatic test_over_range_limits();
        write_reg(bfc_pkg::REG_LEVEL_HIGH, 127);
        write_reg(bfc_pkg::REG_STEP_UP, 100);
        write_reg(bfc_pkg::REG_IDLE_TIMEOUT, bfc_pkg::IDLE_MAX);
        write_reg(bfc_pkg::REG_PWM_FULL, 255);
        repeat (4) send_tick(1'b1, 1'b0);
        settle_ticks();
    endtask

    // low limit above high limit, and a level outside both
    task automatic test_crossed_limits();
        write_reg(bfc_pkg::REG_LEVEL_HIGH, 20);
        write_reg(bfc_pkg::REG_LEVEL_LOW, 100);
        send_tick(1'b1, 1'b0);
        settle_ticks();
        write_reg(bfc_pkg::REG_IDLE_TIMEOUT, 0);
        repeat (2) send_tick(1'b0, 1'b0);
        settle_ticks();
        write_reg(bfc_pkg::REG_STEP_UP, 0);
        write_reg(bfc_pkg::REG_LEVEL_LOW, 0);
        write_reg(bfc_pkg::REG_IDLE_TIMEOUT, bfc_pkg::IDLE_MAX);
        repeat (2) send_tick(1'b1, 1'b0);
        settle_ticks();
    endtask

    // pulse mode steps and duty scale at zero and mid range
    task automatic test_pulse_and_duty();
        write_reg(bfc_pkg::REG_PWM_FULL, 0);
        write_reg(bfc_pkg::REG_PULSE_STEP_UP, 0);
        write_reg(bfc_pkg::REG_PULSE_STEP_DOWN, 100);
        write_reg(bfc_pkg::REG_LEVEL_HIGH, 100);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        settle_ticks();
        write_reg(bfc_pkg::REG_PWM_FULL, 200);
        write_reg(bfc_pkg::REG_PULSE_STEP_UP, 100);
        repeat (2) send_tick(1'b0, 1'b1);
        settle_ticks();
    endtask

    // back-to-back items with the result side always ready
    task automatic test_no_idle_stretch();
        randomize_regs();
        idle_en = 1'b0;
        run_random_ticks(200);
        settle_ticks();
        idle_en = 1'b1;
    endtask

    // several register settings, each with a long random run
    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            randomize_regs();
            run_random_ticks(125);
            settle_ticks();
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: pwm_duty %0d brightness %0d",
                       m_pwm_duty, m_brightness);
                err_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_pwm_duty !== oldest_result.duty) begin
                    $error("pwm_duty mismatch: expected %0d, actual %0d",
                           oldest_result.duty, m_pwm_duty);
                    err_count++;
                end
                if (m_brightness !== oldest_result.brightness) begin
                    $error("brightness mismatch: expected %0d, actual %0d",
                           oldest_result.brightness, m_brightness);
                    err_count++;
                end
            end
        end
    end

    // result side stalls at random while idling is on
    always @(negedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(99) >= 36);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_activity   = 1'b0;
        s_pulse_mode = 1'b0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = bfc_pkg::REG_LEVEL_HIGH;
        cfg_data     = '0;
        idle_en      = 1'b1;
        err_count    = 0;
        cycle_count  = 0;
        reset_model();

        // synchronous reset held low, then released at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_levels();
        test_zero_timeout();
        test_over_range_limits();
        test_crossed_limits();
        test_pulse_and_duty();
        test_no_idle_stretch();
        test_random_phases();

        settle_ticks();
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bfc_pkg.sv
hw/rtl/backlight_fade_controller_core.sv
dv/tb_top.sv
